[design/tie_pkg.sv]
package tie_pkg;

  // request kinds
  localparam logic REQ_CREATE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // easing codes
  localparam logic [1:0] EASE_LINEAR = 2'd0;
  localparam logic [1:0] EASE_IN     = 2'd1;
  localparam logic [1:0] EASE_OUT    = 2'd2;
  localparam logic [1:0] EASE_IN_OUT = 2'd3;

  // one slot entry as held in the slot memory
  typedef struct packed {
    logic [15:0] target;
    logic [31:0] start_value;
    logic [31:0] end_value;
    logic [31:0] start_time;
    logic [15:0] duration;
    logic [1:0]  ease;
  } slot_t;

  // control between the sequencer and the divider
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

endpackage

[design/tween_interpolation_engine_unit.sv]
// Tween table of SLOTS animation slots held in one synchronous slot memory plus
// a row of active flags. One word is handled at a time. A create scans the
// active flags from slot 0 and takes the first free slot. A tick walks every
// slot: an idle slot is skipped, a finishing slot takes its end value, and a
// running slot goes through the bit-serial progress divider and two registered
// multiplies. Results of a tick are held back by one so the last one carries
// last_result; a tick with no active slot gives no result.
module tween_interpolation_engine_unit #(
  parameter int SLOTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [15:0]        target_id_i,
  input  logic signed [31:0] start_value_i,
  input  logic signed [31:0] end_value_i,
  input  logic [15:0]        duration_ms_i,
  input  logic [1:0]         ease_code_i,
  input  logic [31:0]        now_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               result_kind_o,
  output logic [5:0]         slot_index_o,
  output logic               created_ok_o,
  output logic [15:0]        out_target_o,
  output logic signed [31:0] new_value_o,
  output logic               done_res_o,
  output logic               last_result_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CSCAN = 4'd1;
  localparam logic [3:0] ST_CPUT  = 4'd2;
  localparam logic [3:0] ST_TSCAN = 4'd3;
  localparam logic [3:0] ST_TCHK  = 4'd4;
  localparam logic [3:0] ST_TDIV  = 4'd5;
  localparam logic [3:0] ST_TEASE = 4'd6;
  localparam logic [3:0] ST_TSHP  = 4'd7;
  localparam logic [3:0] ST_TMUL  = 4'd8;
  localparam logic [3:0] ST_TVAL  = 4'd9;
  localparam logic [3:0] ST_TPUSH = 4'd10;
  localparam logic [3:0] ST_TEND  = 4'd11;

  logic [3:0]    state_q;
  logic [IW-1:0] idx_q;
  logic [SLOTS-1:0] active_q;

  // latched request
  logic        type_q;
  logic [31:0] now_q;
  tie_pkg::slot_t req_q;

  // slot memory
  tie_pkg::slot_t mem_q [SLOTS];
  tie_pkg::slot_t rd_q;
  logic           mem_we;
  logic           mem_re;

  // tick datapath
  logic [31:0]        elapsed;
  logic               finish;
  logic [15:0]        p_q;
  logic [18:0]        fac;
  logic [34:0]        eprod_q;
  logic [15:0]        e_q;
  logic [15:0]        e_d;
  logic signed [32:0] diff;
  logic signed [49:0] vprod_q;
  logic signed [49:0] vshift;
  logic [31:0]        val_q;
  logic               done_q;

  // held-back tick result
  logic          res_have_q;
  logic [IW-1:0] res_idx_q;
  logic [15:0]   res_tgt_q;
  logic [31:0]   res_val_q;
  logic          res_done_q;

  // output register
  logic        out_valid_q;
  logic        out_free;
  logic        out_load;
  logic        create_ok_q;

  tie_pkg::div_req_t div_req;
  tie_pkg::div_rsp_t div_rsp;

  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = out_free && ((state_q == ST_CPUT) ||
                                   ((state_q == ST_TPUSH) && res_have_q) ||
                                   ((state_q == ST_TEND) && res_have_q));
  assign in_ready_o = (state_q == ST_IDLE);
  assign elapsed    = now_q - rd_q.start_time;
  assign finish     = (rd_q.duration == 16'd0) || (elapsed >= {16'd0, rd_q.duration});
  assign mem_we     = (state_q == ST_CSCAN) && !active_q[idx_q];
  assign mem_re     = (state_q == ST_TSCAN) && active_q[idx_q];
  assign div_req.start = (state_q == ST_TCHK) && !finish;

  tie_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .elapsed_i (elapsed[15:0]),
    .divisor_i (rd_q.duration),
    .rsp_o     (div_rsp)
  );

  // slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[idx_q] <= req_q;
    if (mem_re) rd_q <= mem_q[idx_q];
  end

  // easing multiplier operand
  always_comb begin
    case (rd_q.ease)
      tie_pkg::EASE_IN:  fac = {3'd0, p_q};
      tie_pkg::EASE_OUT: fac = 19'(18'd131072 - {2'd0, p_q});
      tie_pkg::EASE_IN_OUT: begin
        if (!p_q[15]) fac = {3'd0, p_q};
        else fac = 19'(19'd262144 - {2'd0, p_q, 1'b0});
      end
      default: fac = '0;
    endcase
  end

  // easing shape from the product
  always_comb begin
    case (rd_q.ease) inside
      tie_pkg::EASE_IN, tie_pkg::EASE_OUT: e_d = eprod_q[31:16];
      tie_pkg::EASE_IN_OUT: begin
        if (!p_q[15]) e_d = eprod_q[30:15];
        else e_d = 16'((eprod_q - 35'h1_0000_0000) >> 16);
      end
      default: e_d = p_q;
    endcase
  end

  assign diff   = 33'(signed'(rd_q.end_value)) - 33'(signed'(rd_q.start_value));
  assign vshift = vprod_q >>> 16;

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      type_q            <= req_type_i;
      now_q             <= now_ms_i;
      req_q.target      <= target_id_i;
      req_q.start_value <= start_value_i;
      req_q.end_value   <= end_value_i;
      req_q.start_time  <= now_ms_i;
      req_q.duration    <= duration_ms_i;
      req_q.ease        <= ease_code_i;
    end
    if (div_rsp.done) p_q <= div_rsp.quot;
    if (state_q == ST_TEASE) eprod_q <= fac * {19'd0, p_q};
    if (state_q == ST_TSHP) e_q <= e_d;
    if (state_q == ST_TMUL) vprod_q <= diff * signed'({1'b0, e_q});
    if (state_q == ST_TCHK && finish) begin
      val_q  <= rd_q.end_value;
      done_q <= 1'b1;
    end
    if (state_q == ST_TVAL) begin
      val_q  <= rd_q.start_value + vshift[31:0];
      done_q <= 1'b0;
    end
  end

  // sequencer; only one word is in flight so memory accesses never overlap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      active_q    <= '0;
      res_have_q  <= 1'b0;
      out_valid_q <= 1'b0;
      create_ok_q <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            idx_q   <= '0;
            state_q <= (req_type_i == tie_pkg::REQ_TICK) ? ST_TSCAN : ST_CSCAN;
          end
        end
        ST_CSCAN: begin
          if (!active_q[idx_q]) begin
            active_q[idx_q] <= 1'b1;
            create_ok_q     <= 1'b1;
            state_q         <= ST_CPUT;
          end else if (idx_q == LAST_IDX) begin
            create_ok_q <= 1'b0;
            state_q     <= ST_CPUT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_CPUT: begin
          if (out_free) begin
            result_kind_o <= tie_pkg::REQ_CREATE;
            slot_index_o  <= create_ok_q ? 6'(idx_q) : 6'd0;
            created_ok_o  <= create_ok_q;
            out_target_o  <= '0;
            new_value_o   <= '0;
            done_res_o    <= 1'b0;
            last_result_o <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end
        ST_TSCAN: begin
          if (active_q[idx_q]) state_q <= ST_TCHK;
          else if (idx_q == LAST_IDX) state_q <= ST_TEND;
          else idx_q <= idx_q + 1'b1;
        end
        ST_TCHK: begin
          if (finish) begin
            active_q[idx_q] <= 1'b0;
            state_q         <= ST_TPUSH;
          end else begin
            state_q <= ST_TDIV;
          end
        end
        ST_TDIV:  if (div_rsp.done) state_q <= ST_TEASE;
        ST_TEASE: state_q <= ST_TSHP;
        ST_TSHP:  state_q <= ST_TMUL;
        ST_TMUL:  state_q <= ST_TVAL;
        ST_TVAL:  state_q <= ST_TPUSH;
        ST_TPUSH: begin
          if (out_free || !res_have_q) begin
            if (res_have_q) begin
              result_kind_o <= tie_pkg::REQ_TICK;
              slot_index_o  <= 6'(res_idx_q);
              created_ok_o  <= 1'b0;
              out_target_o  <= res_tgt_q;
              new_value_o   <= res_val_q;
              done_res_o    <= res_done_q;
              last_result_o <= 1'b0;
            end
            res_have_q <= 1'b1;
            res_idx_q  <= idx_q;
            res_tgt_q  <= rd_q.target;
            res_val_q  <= val_q;
            res_done_q <= done_q;
            if (idx_q == LAST_IDX) begin
              state_q <= ST_TEND;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_TSCAN;
            end
          end
        end
        ST_TEND: begin
          if (!res_have_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            result_kind_o <= tie_pkg::REQ_TICK;
            slot_index_o  <= 6'(res_idx_q);
            created_ok_o  <= 1'b0;
            out_target_o  <= res_tgt_q;
            new_value_o   <= res_val_q;
            done_res_o    <= res_done_q;
            last_result_o <= 1'b1;
            res_have_q    <= 1'b0;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  a_idle_no_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !res_have_q) else $error("held result left at idle");
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE))
    else $error("accepted word not started");
  a_div_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_TDIV)) else $error("stray divider result");
  a_type_matches_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TSCAN || state_q == ST_TPUSH) |-> (type_q == tie_pkg::REQ_TICK))
    else $error("tick walk for a create");

endmodule

[design/tie_div.sv]
module tie_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tie_pkg::div_req_t  req_i,
  input  logic [15:0]        elapsed_i,
  input  logic [15:0]        divisor_i,
  output tie_pkg::div_rsp_t  rsp_o
);

  // restoring division of elapsed * 2^16 by divisor, one quotient bit a cycle;
  // elapsed is below divisor so the quotient fits in 16 bits
  logic [15:0] rem_q, rem_d;
  logic [15:0] quot_q, quot_d;
  logic [15:0] dvs_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [16:0] shifted;
  logic        fits;

  assign shifted = {rem_q, 1'b0};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = elapsed_i;
      quot_d = '0;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? 16'(shifted - {1'b0, dvs_q}) : shifted[15:0];
      quot_d = {quot_q[14:0], fits};
      cnt_d  = cnt_q + 5'd1;
      if (cnt_q == 5'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (req_i.start) dvs_q <= divisor_i;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without busy");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start) else $error("divider restarted while busy");
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider busy after done");

endmodule

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 64;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic        kind;
    logic [15:0] target;
    logic [31:0] start_value;
    logic [31:0] end_value;
    logic [15:0] duration;
    logic [1:0]  ease;
    logic [31:0] now;
  } req_word_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  slot;
    logic        ok;
    logic [15:0] target;
    logic [31:0] value;
    logic        done;
    logic        last;
  } upd_word_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  req_word_t drv;
  upd_word_t got;

  tween_interpolation_engine_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .req_type_i(drv.kind), .target_id_i(drv.target),
    .start_value_i(drv.start_value), .end_value_i(drv.end_value),
    .duration_ms_i(drv.duration), .ease_code_i(drv.ease), .now_ms_i(drv.now),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .result_kind_o(got.kind), .slot_index_o(got.slot), .created_ok_o(got.ok),
    .out_target_o(got.target), .new_value_o(got.value), .done_res_o(got.done),
    .last_result_o(got.last)
  );

  // tween table mirror
  logic        mir_active [NSLOT];
  logic [15:0] mir_target [NSLOT];
  logic [31:0] mir_start  [NSLOT];
  logic [31:0] mir_end    [NSLOT];
  logic [31:0] mir_time   [NSLOT];
  logic [15:0] mir_dur    [NSLOT];
  logic [1:0]  mir_ease   [NSLOT];

  req_word_t pending_reqs[$];
  upd_word_t expected_updates[$];
  int        errors = 0;
  bit        stim_done = 0;
  logic [31:0] clock_ms = 0;

  function automatic logic [31:0] eased_progress(logic [31:0] p, logic [1:0] code);
    logic [63:0] q;
    q = {32'd0, p};
    case (code)
      tie_pkg::EASE_IN:  return 32'((q * q) >> 16);
      tie_pkg::EASE_OUT: return 32'((q * (64'd131072 - q)) >> 16);
      tie_pkg::EASE_IN_OUT: begin
        if (q < 64'd32768) return 32'((q * q) >> 15);
        return 32'((((64'd262144 - 2 * q) * q) - 64'h1_0000_0000) >> 16);
      end
      default:  return p;
    endcase
  endfunction

  // apply one request to the mirror and queue the updates it causes
  task automatic predict_updates(req_word_t r);
    int i, n;
    logic [31:0] elapsed, p, e;
    longint s, d, v;
    upd_word_t u;
    if (r.kind == tie_pkg::REQ_CREATE) begin
      for (i = 0; i < NSLOT; i++) if (!mir_active[i]) break;
      u = '0;
      u.kind = tie_pkg::REQ_CREATE;
      u.last = 1'b1;
      if (i < NSLOT) begin
        mir_active[i] = 1'b1;
        mir_target[i] = r.target;
        mir_start[i] = r.start_value;
        mir_end[i] = r.end_value;
        mir_dur[i] = r.duration;
        mir_ease[i] = r.ease;
        mir_time[i] = r.now;
        u.slot = 6'(i);
        u.ok = 1'b1;
      end
      expected_updates.push_back(u);
      return;
    end
    n = 0;
    for (i = 0; i < NSLOT; i++) begin
      if (!mir_active[i]) continue;
      u = '0;
      u.kind = tie_pkg::REQ_TICK;
      u.slot = 6'(i);
      u.target = mir_target[i];
      elapsed = r.now - mir_time[i];
      if (mir_dur[i] == 0 || elapsed >= {16'd0, mir_dur[i]}) begin
        mir_active[i] = 1'b0;
        u.value = mir_end[i];
        u.done = 1'b1;
      end else begin
        p = 32'(({32'd0, elapsed} << 16) / mir_dur[i]);
        e = eased_progress(p, mir_ease[i]);
        s = longint'($signed(mir_start[i]));
        d = longint'($signed(mir_end[i])) - s;
        v = s + ((d * longint'(e)) >>> 16);
        u.value = 32'(v);
      end
      expected_updates.push_back(u);
      n++;
    end
    if (n > 0) expected_updates[expected_updates.size() - 1].last = 1'b1;
  endtask

  function automatic req_word_t make_create(logic [15:0] dur, logic [1:0] ease,
                                            logic [31:0] sv, logic [31:0] ev);
    req_word_t r;
    r.kind = tie_pkg::REQ_CREATE;
    r.target = 16'($urandom);
    r.start_value = sv;
    r.end_value = ev;
    r.duration = dur;
    r.ease = ease;
    r.now = clock_ms;
    return r;
  endfunction

  function automatic req_word_t make_tick(logic [31:0] step);
    req_word_t r;
    r = '0;
    r.kind = tie_pkg::REQ_TICK;
    r.target = 16'($urandom);
    r.start_value = $urandom;
    r.end_value = $urandom;
    r.duration = 16'($urandom);
    r.ease = 2'($urandom);
    clock_ms = clock_ms + step;
    r.now = clock_ms;
    return r;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // stimulus
  initial begin
    int k, pick;
    rst_n = 1'b0;
    for (k = 0; k < NSLOT; k++) mir_active[k] = 1'b0;
    // directed: extremes, every easing, zero duration, time wrap, full table
    clock_ms = 32'hFFFF_FFF0;
    pending_reqs.push_back(make_tick(1));
    pending_reqs.push_back(make_create(16'd0, tie_pkg::EASE_LINEAR,
                                       32'h8000_0000, 32'h7FFF_FFFF));
    pending_reqs.push_back(make_create(16'hFFFF, tie_pkg::EASE_IN,
                                       32'h8000_0000, 32'h7FFF_FFFF));
    pending_reqs.push_back(make_create(16'd100, tie_pkg::EASE_OUT,
                                       32'h7FFF_FFFF, 32'h8000_0000));
    pending_reqs.push_back(make_create(16'd100, tie_pkg::EASE_IN_OUT,
                                       32'hFFFF_FFFF, 32'h0001_0000));
    pending_reqs.push_back(make_create(16'd100, tie_pkg::EASE_LINEAR,
                                       32'h0, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_create(16'd40, tie_pkg::EASE_IN_OUT,
                                       32'h1234_5678, 32'hEDCB_A987));
    pending_reqs.push_back(make_tick(20));
    pending_reqs.push_back(make_tick(30));
    pending_reqs.push_back(make_tick(99));
    pending_reqs.push_back(make_tick(32'hFFFF_FFFF));
    // fill the table, overflow it, then drain it
    for (k = 0; k < NSLOT + 2; k++)
      pending_reqs.push_back(make_create(16'(k + 1), 2'(k), $urandom, $urandom));
    pending_reqs.push_back(make_tick(NSLOT + 5));
    // random: mostly short tweens with ticks walking time forward
    for (k = 0; k < 120; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)
        pending_reqs.push_back(make_create(
          ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60)),
          2'($urandom), $urandom, $urandom));
      else if (pick < 9)
        pending_reqs.push_back(make_tick($urandom_range(0, 25)));
      else
        pending_reqs.push_back(make_tick($urandom));
    end
    pending_reqs.push_back(make_tick(32'h8000_0000));
    pending_reqs.push_back(make_tick(32'h7FFF_FFFF));
    pending_reqs.push_back(make_tick(70000));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // all words handed over and accepted
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    stim_done = 1'b1;
  end

  // driver
  int in_wait = 0;
  initial begin
    in_valid = 1'b0;
    drv = '0;
  end
  always @(negedge clk) begin
    if (rst_n && !in_valid) begin
      if (in_wait > 0) in_wait <= in_wait - 1;
      else if (pending_reqs.size() > 0) begin
        drv <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end
    end
  end
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      predict_updates(drv);
      in_valid <= 1'b0;
      in_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    end
  end

  // result sink stall
  int out_wait = 0;
  initial out_ready = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_wait > 0) begin
        out_wait <= out_wait - 1;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    upd_word_t x;
    if (rst_n && out_valid && out_ready) begin
      out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (expected_updates.size() == 0) begin
        $error("unexpected word kind=%0d slot=%0d", got.kind, got.slot);
        errors++;
      end else begin
        x = expected_updates.pop_front();
        if (got.kind !== x.kind) begin
          $error("result_kind exp %0d got %0d", x.kind, got.kind); errors++;
        end
        if (got.slot !== x.slot) begin
          $error("slot_index exp %0d got %0d", x.slot, got.slot); errors++;
        end
        if (got.ok !== x.ok) begin
          $error("created_ok exp %0d got %0d", x.ok, got.ok); errors++;
        end
        if (got.target !== x.target) begin
          $error("out_target exp %h got %h", x.target, got.target); errors++;
        end
        if (got.value !== x.value) begin
          $error("new_value exp %h got %h", x.value, got.value); errors++;
        end
        if (got.done !== x.done) begin
          $error("done_res exp %0d got %0d", x.done, got.done); errors++;
        end
        if (got.last !== x.last) begin
          $error("last_result exp %0d got %0d", x.last, got.last); errors++;
        end
      end
    end
  end

  // end of run and watchdog
  int cycles = 0;
  always @(posedge clk) cycles <= cycles + 1;
  initial begin
    @(posedge clk);
    while (!stim_done || expected_updates.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (expected_updates.size() != 0) errors++;
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
  initial begin
    @(posedge clk);
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
